>>> rtl/gshb_pkg.sv
// gshb_pkg: shared types, constants and helpers for the gshare predictor with btb
// no dependencies; imported by the predictor top level
`default_nettype none

package gshb_pkg;

  // default sizes
  localparam int HISTORY_BITS_DEF      = 8;
  localparam int BUFFER_INDEX_BITS_DEF = 10;

  // address width and fall-through increment
  localparam int          PC_W       = 64;
  localparam logic [63:0] INSN_BYTES = 64'd4;

  // two-bit saturating counter limits
  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic [1:0] CTR_MIN = 2'd0;

  // request kinds
  typedef enum logic {
    REQ_PREDICT = 1'b0,
    REQ_UPDATE  = 1'b1
  } req_type_t;

  // one target buffer entry as stored in memory
  typedef struct packed {
    logic            valid;
    logic            cond;
    logic [PC_W-1:0] tag;
    logic [PC_W-1:0] target;
  } btb_entry_t;

  localparam int BTB_ENTRY_W = $bits(btb_entry_t);

  // saturating counter step
  function automatic logic [1:0] ctr_step(input logic [1:0] ctr, input logic taken);
    logic [1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gshb_sram.sv
// gshb_sram: single-port-write, single-port-read synchronous memory, registered read
// no dependencies; used for the target buffer and the counter table
`default_nettype none

module gshb_sram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_W    = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_W-1:0]    rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]    wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_BITS];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/gshare_predictor_with_btb_unit.sv
// gshare_predictor_with_btb_unit: top level, request sequencer, history and output register
// depends on gshb_pkg and gshb_sram
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per transfer: a predict
//   for a fetch pc, or an update with a resolved branch. Output channel
//   (out_valid/out_ready) carries one transfer per predict request; updates give none.
//   The memory read for a request is issued with its transfer; the read data
//   arrive in the next cycle, where the request is resolved (result or write-back).
//   The prediction passes from the lookup step into the output register and then
//   shows on out_valid. A new request is taken only after the last one has left
//   the lookup step, as the memory read is followed by the read-modify-write of
//   the counter and buffer entry.
//   Reset: history cleared, then a clearing pass over both memories; in_ready
//   stays low during it.
//   Stall: a finished prediction waits in the output register; a following
//   request may be taken meanwhile, and its own prediction waits in the lookup
//   step until the output register frees up.
`default_nettype none

module gshare_predictor_with_btb_unit
  import gshb_pkg::*;
#(
  parameter int HISTORY_BITS      = HISTORY_BITS_DEF,
  parameter int BUFFER_INDEX_BITS = BUFFER_INDEX_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_req_type,
  input  wire logic [PC_W-1:0] in_pc,
  input  wire logic            in_is_conditional,
  input  wire logic [PC_W-1:0] in_target_pc,
  input  wire logic            in_taken,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [PC_W-1:0]      out_pred_pc,
  output logic                 out_buffer_miss
);

  localparam int CLR_BITS = (BUFFER_INDEX_BITS > HISTORY_BITS) ? BUFFER_INDEX_BITS
                                                               : HISTORY_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CLR_BITS-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [HISTORY_BITS-1:0]  hist_r, hist_nxt;
  logic                     req_r, req_nxt;
  logic [PC_W-1:0]          pc_r, pc_nxt;
  logic                     cond_r, cond_nxt;
  logic [PC_W-1:0]          target_r, target_nxt;
  logic                     taken_r, taken_nxt;
  logic [HISTORY_BITS-1:0]  pi_r, pi_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [PC_W-1:0]          out_pred_pc_r, out_pred_pc_nxt;
  logic                     out_miss_r, out_miss_nxt;

  logic                     in_fire;
  logic [HISTORY_BITS-1:0]  in_pi;

  logic                         btb_we;
  logic [BUFFER_INDEX_BITS-1:0] btb_waddr;
  btb_entry_t                   btb_wentry;
  logic [BTB_ENTRY_W-1:0]       btb_rdata;
  btb_entry_t                   btb_q;

  logic                     pht_we;
  logic [HISTORY_BITS-1:0]  pht_waddr;
  logic [1:0]               pht_wdata;
  logic [1:0]               pht_q;

  logic                     hit;
  logic                     use_target;
  logic [PC_W-1:0]          pred_pc;
  logic                     out_free;
  logic                     lookup_upd;

  // input transfer and gshare index
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_pi    = hist_r ^ in_pc[2 +: HISTORY_BITS];

  // target buffer memory
  gshb_sram #(
    .ADDR_BITS (BUFFER_INDEX_BITS),
    .DATA_W    (BTB_ENTRY_W)
  ) u_btb_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_pc[2 +: BUFFER_INDEX_BITS]),
    .rd_data (btb_rdata),
    .wr_en   (btb_we),
    .wr_addr (btb_waddr),
    .wr_data (btb_wentry)
  );

  // pattern counter memory
  gshb_sram #(
    .ADDR_BITS (HISTORY_BITS),
    .DATA_W    (2)
  ) u_pht_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_pi),
    .rd_data (pht_q),
    .wr_en   (pht_we),
    .wr_addr (pht_waddr),
    .wr_data (pht_wdata)
  );

  assign btb_q = btb_entry_t'(btb_rdata);

  // prediction from the read data
  assign hit        = btb_q.valid && (btb_q.tag == pc_r);
  assign use_target = hit && (!btb_q.cond || pht_q[1]);
  assign pred_pc    = use_target ? btb_q.target : (pc_r + INSN_BYTES);
  assign out_free   = !out_valid_r || out_ready;
  assign lookup_upd = (state_r == ST_LOOKUP) && (req_r == REQ_UPDATE);

  // memory write ports: clearing pass or update write-back
  always_comb begin
    btb_we     = 1'b0;
    btb_waddr  = pc_r[2 +: BUFFER_INDEX_BITS];
    btb_wentry = '{valid: 1'b1, cond: cond_r, tag: pc_r, target: target_r};
    pht_we     = 1'b0;
    pht_waddr  = pi_r;
    pht_wdata  = ctr_step(pht_q, taken_r);
    if (state_r == ST_CLEAR) begin
      btb_we     = 1'b1;
      btb_waddr  = clr_cnt_r[BUFFER_INDEX_BITS-1:0];
      btb_wentry = '0;
      pht_we     = 1'b1;
      pht_waddr  = clr_cnt_r[HISTORY_BITS-1:0];
      pht_wdata  = CTR_MIN;
    end else if (lookup_upd) begin
      btb_we = 1'b1;
      pht_we = cond_r;
    end
  end

  // sequencer, history and output register next values
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    hist_nxt        = hist_r;
    req_nxt         = req_r;
    pc_nxt          = pc_r;
    cond_nxt        = cond_r;
    target_nxt      = target_r;
    taken_nxt       = taken_r;
    pi_nxt          = pi_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_pred_pc_nxt = out_pred_pc_r;
    out_miss_nxt    = out_miss_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt    = in_req_type;
          pc_nxt     = in_pc;
          cond_nxt   = in_is_conditional;
          target_nxt = in_target_pc;
          taken_nxt  = in_taken;
          pi_nxt     = in_pi;
          state_nxt  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (req_r == REQ_UPDATE) begin
          if (cond_r) begin
            hist_nxt = {hist_r[HISTORY_BITS-2:0], taken_r};
          end
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_pred_pc_nxt = pred_pc;
          out_miss_nxt    = !hit;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r         <= req_nxt;
    pc_r          <= pc_nxt;
    cond_r        <= cond_nxt;
    target_r      <= target_nxt;
    taken_r       <= taken_nxt;
    pi_r          <= pi_nxt;
    out_pred_pc_r <= out_pred_pc_nxt;
    out_miss_r    <= out_miss_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pred_pc     = out_pred_pc_r;
  assign out_buffer_miss = out_miss_r;

  // a transfer always moves on to the lookup step
  a_fire_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOOKUP))
    else $error("accepted request did not enter lookup");

  // an update never produces a result
  a_update_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_upd |=> (state_r == ST_IDLE) && (out_valid_r == $past(out_valid_r && !out_ready)))
    else $error("update produced a result or stalled");

  // unconditional updates leave the history alone
  a_uncond_hist: assert property (@(posedge clk) disable iff (!rst_n)
    (lookup_upd && !cond_r) |=> $stable(hist_r))
    else $error("history moved on an unconditional update");

  // memory read and write never overlap
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && (btb_we || pht_we)))
    else $error("memory read and write in the same cycle");

  // a new result only comes out of the lookup step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOKUP && req_r == REQ_PREDICT))
    else $error("result raised outside a predict lookup");

endmodule

`default_nettype wire
